/* rtl/upd_pkg.sv */
// Shared types and constants for the URL percent decoder.
`timescale 1ns / 1ps

package upd_pkg;

	localparam logic [7:0] CH_PERCENT = 8'h25;
	localparam logic [7:0] CH_PLUS    = 8'h2B;
	localparam logic [7:0] CH_SPACE   = 8'h20;

	localparam int unsigned CAP_WIDTH  = 16;
	localparam logic [CAP_WIDTH-1:0] CAP_RESET = 16'hFFFF;
	localparam int unsigned LEN_WIDTH  = 16;

	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

	// One emit request from the front to the back.
	typedef struct packed {
		logic [7:0] data;  // byte to emit (already '+' mapped or hex decoded)
		logic       last;  // string ends with this entry
		logic       pct;   // short escape at the end: emit '%' before data
	} upd_entry_t;

endpackage

/* rtl/upd_front.sv */
// Front end: accepts source bytes, tracks escapes and hex-decodes them.
`timescale 1ns / 1ps

module upd_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         in_byte,
	input  logic               in_last,
	input  logic               q_full,
	output logic               push,
	output upd_pkg::upd_entry_t push_entry
);

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_PCT,
		PH_DIGIT
	} phase_t;

	phase_t     phase_q;
	logic [7:0] first_char_q;
	logic [7:0] prev_value_q;

	logic       accept;
	logic [4:0] d1;
	logic [4:0] d2;
	logic [7:0] new_prev;
	logic [7:0] plain_byte;

	// {hit, value}
	function automatic logic [4:0] hex_val(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b1, 4'(c - 8'h30)};
		end else if (c >= 8'h61 && c <= 8'h66) begin
			r = {1'b1, 4'(c - 8'h57)};
		end else if (c >= 8'h41 && c <= 8'h46) begin
			r = {1'b1, 4'(c - 8'h37)};
		end
		return r;
	endfunction

	assign in_ready   = !q_full;
	assign accept     = in_valid && in_ready;
	assign plain_byte = (in_byte == upd_pkg::CH_PLUS) ? upd_pkg::CH_SPACE : in_byte;
	assign d1         = hex_val(first_char_q);
	assign d2         = hex_val(in_byte);

	always_comb begin
		if (d1[4]) begin
			new_prev = d2[4] ? {d1[3:0], d2[3:0]} : {4'd0, d1[3:0]};
		end else begin
			new_prev = prev_value_q;
		end
	end

	always_comb begin
		push            = 1'b0;
		push_entry.data = plain_byte;
		push_entry.last = in_last;
		push_entry.pct  = 1'b0;
		case (phase_q)
			PH_PCT: begin
				push           = accept && in_last;
				push_entry.pct = 1'b1;
			end
			PH_DIGIT: begin
				push            = accept;
				push_entry.data = new_prev;
			end
			default: begin
				push = accept && !(in_byte == upd_pkg::CH_PERCENT && !in_last);
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			first_char_q <= 8'd0;
			prev_value_q <= 8'd0;
		end else if (accept) begin
			case (phase_q)
				PH_PCT: begin
					first_char_q <= in_byte;
					phase_q      <= PH_DIGIT;
				end
				PH_DIGIT: begin
					prev_value_q <= new_prev;
					phase_q      <= PH_IDLE;
				end
				default: begin
					phase_q <= (in_byte == upd_pkg::CH_PERCENT) ? PH_PCT : PH_IDLE;
				end
			endcase
			// end of string clears the per-string state
			if (in_last) begin
				phase_q      <= PH_IDLE;
				prev_value_q <= 8'd0;
			end
		end
	end

endmodule

/* rtl/upd_queue.sv */
// Small register FIFO between front and back.
`timescale 1ns / 1ps

module upd_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  upd_pkg::upd_entry_t push_entry,
	input  logic                pop,
	output logic                full,
	output logic                not_empty,
	output upd_pkg::upd_entry_t head
);

	localparam int unsigned CNT_W = upd_pkg::QUEUE_PTR_W + 1;

	upd_pkg::upd_entry_t mem_q [upd_pkg::QUEUE_DEPTH];

	logic [upd_pkg::QUEUE_PTR_W-1:0] wr_ptr_q;
	logic [upd_pkg::QUEUE_PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0]                count_q;

	logic do_push;
	logic do_pop;

	assign full      = (count_q == CNT_W'(upd_pkg::QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign head      = mem_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

/* rtl/upd_back.sv */
// Back end: output counting, capacity check, dropping and result register.
`timescale 1ns / 1ps

module upd_back #(
	parameter int unsigned COUNT_WIDTH = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic [upd_pkg::CAP_WIDTH-1:0]    capacity,
	input  logic                             q_not_empty,
	input  upd_pkg::upd_entry_t              head,
	output logic                             pop,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [7:0]                       out_byte,
	output logic                             byte_valid,
	output logic                             is_last,
	output logic                             overflow,
	output logic [upd_pkg::LEN_WIDTH-1:0]    total_length
);

	localparam int unsigned CMP_W = (COUNT_WIDTH + 1 > upd_pkg::LEN_WIDTH) ?
		COUNT_WIDTH + 1 : upd_pkg::LEN_WIDTH;

	logic [COUNT_WIDTH-1:0] count_q;
	logic                   dropping_q;
	logic                   pct_done_q;

	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       byte_valid_q;
	logic       is_last_q;
	logic       overflow_q;
	logic [upd_pkg::LEN_WIDTH-1:0] total_length_q;

	logic [CMP_W-1:0] sum;
	logic             ovf_hit;
	logic             slot_free;
	logic             emit_pct;
	logic [7:0]       emit_byte;
	logic             emit_final;
	logic             can_go;
	logic             load;

	assign sum        = CMP_W'(count_q) + CMP_W'(1);
	assign ovf_hit    = (sum >= CMP_W'(capacity));
	assign slot_free  = !out_valid_q || out_ready;
	assign emit_pct   = head.pct && !pct_done_q;
	assign emit_byte  = emit_pct ? upd_pkg::CH_PERCENT : head.data;
	assign emit_final = emit_pct ? 1'b0 : head.last;
	// dropped entries retire without needing the output slot
	assign can_go     = q_not_empty && (dropping_q || slot_free);
	assign load       = can_go && !dropping_q;
	assign pop        = can_go && (dropping_q || !emit_pct || ovf_hit);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			dropping_q  <= 1'b0;
			pct_done_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (slot_free) begin
				out_valid_q <= load;
			end
			if (load) begin
				if (ovf_hit) begin
					dropping_q <= 1'b1;
				end else begin
					count_q <= sum[COUNT_WIDTH-1:0];
					if (emit_pct) begin
						pct_done_q <= 1'b1;
					end
				end
			end
			if (pop) begin
				pct_done_q <= 1'b0;
				if (head.last) begin
					count_q    <= '0;
					dropping_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (ovf_hit) begin
				out_byte_q     <= 8'd0;
				byte_valid_q   <= 1'b0;
				is_last_q      <= head.last;
				overflow_q     <= 1'b1;
				total_length_q <= '0;
			end else begin
				out_byte_q     <= emit_byte;
				byte_valid_q   <= 1'b1;
				is_last_q      <= emit_final;
				overflow_q     <= 1'b0;
				total_length_q <= emit_final ?
					upd_pkg::LEN_WIDTH'(sum[COUNT_WIDTH-1:0]) : '0;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign out_byte     = out_byte_q;
	assign byte_valid   = byte_valid_q;
	assign is_last      = is_last_q;
	assign overflow     = overflow_q;
	assign total_length = total_length_q;

endmodule

/* rtl/url_percent_decoder.sv */
// URL percent decoder top level: front, queue, back and capacity register.
// Path: a source byte transfer is written into the queue, then loaded into the
//   result register before it is presented.
// Throughput: one source byte per cycle while the queue is not full; a
//   short escape at the end of a string holds the back end for two results.
// Reset: asynchronous, clears escape state, counts, queue and output valid;
//   the capacity register returns to 65535.
`timescale 1ns / 1ps

module url_percent_decoder #(
	parameter int unsigned COUNT_WIDTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  in_byte,
	input  logic        in_last,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_byte,
	output logic        byte_valid,
	output logic        is_last,
	output logic        overflow,
	output logic [15:0] total_length,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data
);

	logic [upd_pkg::CAP_WIDTH-1:0] capacity_q;

	logic                q_full;
	logic                q_not_empty;
	logic                push;
	logic                pop;
	upd_pkg::upd_entry_t push_entry;
	upd_pkg::upd_entry_t head;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= upd_pkg::CAP_RESET;
		end else if (cfg_valid && cfg_ready) begin
			capacity_q <= cfg_data;
		end
	end

	upd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_byte    (in_byte),
		.in_last    (in_last),
		.q_full     (q_full),
		.push       (push),
		.push_entry (push_entry)
	);

	upd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.full       (q_full),
		.not_empty  (q_not_empty),
		.head       (head)
	);

	upd_back #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.capacity     (capacity_q),
		.q_not_empty  (q_not_empty),
		.head         (head),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_byte     (out_byte),
		.byte_valid   (byte_valid),
		.is_last      (is_last),
		.overflow     (overflow),
		.total_length (total_length)
	);

	// a length is reported only on a valid final byte
	a_len_only_final: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (total_length != 16'd0) |-> is_last && byte_valid && !overflow)
		else $error("total_length set on a non-final result");

	// an error result never carries a byte
	a_ovf_no_byte: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && overflow |-> !byte_valid && (out_byte == 8'd0))
		else $error("overflow result carries a byte");

	// a capacity write lands in the register
	a_cfg_write: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready |=> capacity_q == $past(cfg_data))
		else $error("capacity write lost");

	// a held result keeps its slot until the transfer
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(is_last))
		else $error("stalled result changed");

endmodule
